### sv/tlut_pkg.sv
// Shared constants, types and arithmetic helpers for the trilinear 3D LUT sampler.
// Depends on nothing; tlut_if and the sampler top import it.
`default_nettype none

package tlut_pkg;

	localparam int MAX_GRID        = 33;
	localparam int COORD_FRAC_BITS = 16;
	localparam int NODE_BITS       = 16;

	localparam int TABLE_DEPTH = MAX_GRID * MAX_GRID * MAX_GRID;
	localparam int CFG_W       = 6;
	localparam int IDX_W       = 16;
	localparam int COORD_W     = COORD_FRAC_BITS + 1;
	localparam int GRID_W      = $clog2(MAX_GRID + 1);
	localparam int AXIS_W      = $clog2(MAX_GRID);
	localparam int BG_W        = $clog2(MAX_GRID * MAX_GRID);
	localparam int ROW_W       = $clog2(TABLE_DEPTH + 1);
	localparam int BANK_DEPTH  = (TABLE_DEPTH + 1) / 2;
	localparam int BANK_AW     = $clog2(BANK_DEPTH);
	localparam int ENTRY_W     = 3 * NODE_BITS;
	localparam int PROD_W      = NODE_BITS + COORD_FRAC_BITS + 2;
	localparam int WIDE_W      = NODE_BITS + 2;
	localparam int NODE_MAX    = 2 ** (NODE_BITS - 1) - 1;
	localparam int NODE_MIN    = -(2 ** (NODE_BITS - 1));
	localparam int N_ROWS      = 4;

	typedef enum logic {
		KIND_LOAD   = 1'b0,
		KIND_SAMPLE = 1'b1
	} kind_t;

	typedef logic signed [NODE_BITS-1:0] node_t;
	typedef logic signed [WIDE_W-1:0]    wide_t;
	typedef logic [COORD_FRAC_BITS-1:0]  frac_t;
	typedef logic [AXIS_W-1:0]           axis_t;
	typedef logic [GRID_W-1:0]           grid_t;

	typedef struct packed {
		node_t red;
		node_t green;
		node_t blue;
	} rgb_t;

	typedef struct packed {
		axis_t lo;
		axis_t up;
		frac_t f;
	} axis_split_t;

	// Register value limited to the legal range of nodes per axis.
	function automatic grid_t grid_limit(logic [CFG_W-1:0] g);
		grid_t r;
		if (GRID_W'(g) < GRID_W'(2)) begin
			r = GRID_W'(2);
		end else if (GRID_W'(g) > GRID_W'(MAX_GRID) || g > CFG_W'(MAX_GRID)) begin
			r = GRID_W'(MAX_GRID);
		end else begin
			r = GRID_W'(g);
		end
		return r;
	endfunction

	// Clamp to 1.0, scale by s-1, split into lower corner, upper corner and fraction.
	function automatic axis_split_t split_axis(logic [COORD_W-1:0] c, grid_t s);
		logic [COORD_W-1:0]        cc;
		logic [COORD_W+GRID_W-1:0] p;
		axis_t                     lo;
		axis_split_t               r;
		cc = (c > (COORD_W'(1) << COORD_FRAC_BITS)) ? (COORD_W'(1) << COORD_FRAC_BITS) : c;
		p  = (COORD_W+GRID_W)'(cc) * (COORD_W+GRID_W)'(s - GRID_W'(1));
		lo = AXIS_W'(p >> COORD_FRAC_BITS);
		r.lo = lo;
		r.f  = p[COORD_FRAC_BITS-1:0];
		r.up = ((GRID_W'(lo) + GRID_W'(1)) < s) ? AXIS_W'(lo + AXIS_W'(1)) : lo;
		return r;
	endfunction

	// a + floor(((b - a) * f + half) / one), which equals the weighted blend rounded half up.
	function automatic wide_t blend(node_t a, node_t b, frac_t f);
		logic signed [NODE_BITS:0] d;
		logic signed [PROD_W-1:0]  prod;
		logic signed [PROD_W-1:0]  rnd;
		d    = {b[NODE_BITS-1], b} - {a[NODE_BITS-1], a};
		prod = PROD_W'(d) * $signed({{(PROD_W-COORD_FRAC_BITS){1'b0}}, f});
		rnd  = prod + PROD_W'(2 ** (COORD_FRAC_BITS - 1));
		return WIDE_W'(a) + WIDE_W'(rnd >>> COORD_FRAC_BITS);
	endfunction

	function automatic node_t saturate(wide_t v);
		node_t r;
		if (v > WIDE_W'(NODE_MAX)) begin
			r = NODE_BITS'(NODE_MAX);
		end else if (v < WIDE_W'(NODE_MIN)) begin
			r = NODE_BITS'(NODE_MIN);
		end else begin
			r = NODE_BITS'(v);
		end
		return r;
	endfunction

	function automatic rgb_t blend_rgb(rgb_t a, rgb_t b, frac_t f);
		rgb_t r;
		r.red   = NODE_BITS'(blend(a.red, b.red, f));
		r.green = NODE_BITS'(blend(a.green, b.green, f));
		r.blue  = NODE_BITS'(blend(a.blue, b.blue, f));
		return r;
	endfunction

endpackage

`default_nettype wire

### sv/tlut_if.sv
// Valid/ready channel interfaces for the sampler: request items and result items.
// Depends on tlut_pkg for field widths and the item kind.
`default_nettype none

interface tlut_req_if import tlut_pkg::*;;
	logic                          valid;
	logic                          ready;
	kind_t                         kind;
	logic [IDX_W-1:0]              node_index;
	logic signed [NODE_BITS-1:0]   node_red;
	logic signed [NODE_BITS-1:0]   node_green;
	logic signed [NODE_BITS-1:0]   node_blue;
	logic [COORD_W-1:0]            coord_red;
	logic [COORD_W-1:0]            coord_green;
	logic [COORD_W-1:0]            coord_blue;

	modport source (output valid, kind, node_index, node_red, node_green, node_blue,
		coord_red, coord_green, coord_blue, input ready);
	modport sink (input valid, kind, node_index, node_red, node_green, node_blue,
		coord_red, coord_green, coord_blue, output ready);
endinterface

interface tlut_rsp_if import tlut_pkg::*;;
	logic                          valid;
	logic                          ready;
	logic signed [NODE_BITS-1:0]   out_red;
	logic signed [NODE_BITS-1:0]   out_green;
	logic signed [NODE_BITS-1:0]   out_blue;

	modport source (output valid, out_red, out_green, out_blue, input ready);
	modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

`default_nettype wire

### sv/tlut_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module tlut_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### sv/trilinear_3d_lut_sampler.sv
// Top level of the trilinear 3D color LUT sampler: six-stage pipeline and banked node tables.
// Depends on tlut_pkg, tlut_req_if, tlut_rsp_if and tlut_ram.
//
// Usage. The req channel carries two kinds of beat. A load beat writes one RGB node
// (signed Q3.12) at linear index blue*size*size + green*size + red; an index at or past
// the full table depth is dropped, and a load produces no result beat. A sample beat
// carries an unsigned Q1.16 RGB coordinate and produces exactly one result beat on rsp with the
// trilinearly blended, saturated color. Beats are handled strictly in order, so a sample
// sees every load accepted before it.
// The grid_size register (nodes per axis) is written through cfg_we/cfg_wdata; the user must
// do so only while the pipeline is empty, as the block itself does not enforce it. Values below 2
// act as 2 and values above 33 act as 33. Throughput is one beat per clock while rsp is not
// stalled. The node table is kept in four copies, one per green/blue corner row, and each
// copy is split into even and odd banks by linear index, so the two red neighbors of all
// four rows are read in the same cycle. The stages are: axis split (one coordinate
// multiply), row base, node address and banked read, red blend, green blend, blue blend
// with saturation. When rsp stalls, the whole pipeline holds and req.ready drops; nothing
// is lost or repeated. Reset clears every valid bit and sets grid_size to 33; the node
// table is not cleared and a sample must only touch nodes that were loaded.
`default_nettype none

module trilinear_3d_lut_sampler import tlut_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	tlut_req_if.sink          req,
	tlut_rsp_if.source        rsp,
	input  logic              cfg_we,
	input  logic [CFG_W-1:0]  cfg_wdata
);

	logic [CFG_W-1:0] grid_q;
	grid_t            s_eff;
	logic             en;
	logic             accept;

	// Stage 1: axis split.
	logic             vld_s1;
	kind_t            kind_s1;
	logic [IDX_W-1:0] idx_s1;
	rgb_t             node_s1;
	axis_split_t      ax_r_s1, ax_g_s1, ax_b_s1;

	// Stage 2: row bases b*s + g for the four green/blue corners.
	logic             vld_s2;
	kind_t            kind_s2;
	logic [IDX_W-1:0] idx_s2;
	rgb_t             node_s2;
	axis_t            rlo_s2;
	logic             rsame_s2;
	frac_t            fr_s2, fg_s2, fb_s2;
	logic [BG_W-1:0]  bg_s2 [N_ROWS];

	// Stage 3: banked read data.
	logic             vld_s3;
	kind_t            kind_s3;
	logic             rsame_s3;
	logic             par_s3 [N_ROWS];
	frac_t            fr_s3, fg_s3, fb_s3;

	// Stages 4 to 6: blends.
	logic             vld_s4, vld_s5, vld_s6;
	kind_t            kind_s4, kind_s5, kind_s6;
	frac_t            fg_s4, fb_s4, fb_s5;
	rgb_t             x_s4 [N_ROWS];
	rgb_t             y_s5 [2];
	rgb_t             out_s6;

	logic [ROW_W-1:0]   row_addr [N_ROWS];
	logic [ROW_W-1:0]   row_addr_p1 [N_ROWS];
	logic               tbl_we_even, tbl_we_odd;
	logic [ENTRY_W-1:0] rd_even [N_ROWS];
	logic [ENTRY_W-1:0] rd_odd [N_ROWS];
	rgb_t               x_n [N_ROWS];

	assign s_eff  = grid_limit(grid_q);
	// The pipeline moves as a whole; it only holds while a result waits to be taken.
	assign en     = !rsp.valid || rsp.ready;
	assign accept = req.valid && en;
	assign req.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q <= CFG_W'(MAX_GRID);
		end else if (cfg_we) begin
			grid_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// Stage 1 and 2 payload.
	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= req.kind;
			idx_s1  <= req.node_index;
			node_s1 <= '{red: req.node_red, green: req.node_green, blue: req.node_blue};
			ax_r_s1 <= split_axis(req.coord_red, s_eff);
			ax_g_s1 <= split_axis(req.coord_green, s_eff);
			ax_b_s1 <= split_axis(req.coord_blue, s_eff);

			kind_s2  <= kind_s1;
			idx_s2   <= idx_s1;
			node_s2  <= node_s1;
			rlo_s2   <= ax_r_s1.lo;
			rsame_s2 <= (ax_r_s1.lo == ax_r_s1.up);
			fr_s2    <= ax_r_s1.f;
			fg_s2    <= ax_g_s1.f;
			fb_s2    <= ax_b_s1.f;
			for (int k = 0; k < N_ROWS; k++) begin
				bg_s2[k] <= BG_W'(BG_W'(k[1] ? ax_b_s1.up : ax_b_s1.lo) * BG_W'(s_eff)
					+ BG_W'(k[0] ? ax_g_s1.up : ax_g_s1.lo));
			end
		end
	end

	// Row k holds corners (r0, r1) of green/blue pair k; bit 0 of k picks green, bit 1 blue.
	always_comb begin
		for (int k = 0; k < N_ROWS; k++) begin
			row_addr[k]    = ROW_W'(ROW_W'(bg_s2[k]) * ROW_W'(s_eff) + ROW_W'(rlo_s2));
			row_addr_p1[k] = ROW_W'(row_addr[k] + ROW_W'(1));
		end
	end

	// Loads write every copy; the parity of the index picks the bank.
	always_comb begin
		tbl_we_even = 1'b0;
		tbl_we_odd  = 1'b0;
		if (en && vld_s2 && kind_s2 == KIND_LOAD && ROW_W'(idx_s2) < ROW_W'(TABLE_DEPTH)) begin
			tbl_we_even = !idx_s2[0];
			tbl_we_odd  = idx_s2[0];
		end
	end

	for (genvar k = 0; k < N_ROWS; k++) begin : g_copy
		// The even bank gets the even one of (a, a+1), the odd bank the odd one.
		tlut_ram #(.WIDTH(ENTRY_W), .DEPTH(BANK_DEPTH)) u_even (
			.clk   (clk),
			.we    (tbl_we_even),
			.waddr (idx_s2[BANK_AW:1]),
			.wdata (node_s2),
			.re    (en),
			.raddr (row_addr_p1[k][BANK_AW:1]),
			.rdata (rd_even[k])
		);
		tlut_ram #(.WIDTH(ENTRY_W), .DEPTH(BANK_DEPTH)) u_odd (
			.clk   (clk),
			.we    (tbl_we_odd),
			.waddr (idx_s2[BANK_AW:1]),
			.wdata (node_s2),
			.re    (en),
			.raddr (row_addr[k][BANK_AW:1]),
			.rdata (rd_odd[k])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s3  <= kind_s2;
			rsame_s3 <= rsame_s2;
			fr_s3    <= fr_s2;
			fg_s3    <= fg_s2;
			fb_s3    <= fb_s2;
			for (int k = 0; k < N_ROWS; k++) begin
				par_s3[k] <= row_addr[k][0];
			end
		end
	end

	// Red blend. At the top red edge both corners are the same node, so the lower one is
	// reused rather than the unrelated node past the row end.
	always_comb begin
		rgb_t lo_n;
		rgb_t hi_n;
		for (int k = 0; k < N_ROWS; k++) begin
			lo_n   = par_s3[k] ? rgb_t'(rd_odd[k]) : rgb_t'(rd_even[k]);
			hi_n   = rsame_s3 ? lo_n : (par_s3[k] ? rgb_t'(rd_even[k]) : rgb_t'(rd_odd[k]));
			x_n[k] = blend_rgb(lo_n, hi_n, fr_s3);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s4 <= kind_s3;
			fg_s4   <= fg_s3;
			fb_s4   <= fb_s3;
			for (int k = 0; k < N_ROWS; k++) begin
				x_s4[k] <= x_n[k];
			end

			kind_s5 <= kind_s4;
			fb_s5   <= fb_s4;
			y_s5[0] <= blend_rgb(x_s4[0], x_s4[1], fg_s4);
			y_s5[1] <= blend_rgb(x_s4[2], x_s4[3], fg_s4);

			kind_s6 <= kind_s5;
			out_s6.red   <= saturate(blend(y_s5[0].red, y_s5[1].red, fb_s5));
			out_s6.green <= saturate(blend(y_s5[0].green, y_s5[1].green, fb_s5));
			out_s6.blue  <= saturate(blend(y_s5[0].blue, y_s5[1].blue, fb_s5));
		end
	end

	assign rsp.valid     = vld_s6 && kind_s6 == KIND_SAMPLE;
	assign rsp.out_red   = out_s6.red;
	assign rsp.out_green = out_s6.green;
	assign rsp.out_blue  = out_s6.blue;

`ifndef SYNTH
	// With no result waiting, the pipeline must be open for a new beat.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp.valid |-> req.ready)
		else $error("request channel blocked with no pending result");

	// A load leaving the last blend stage never shows up as a result.
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s5 && kind_s5 == KIND_LOAD && en) |=> !rsp.valid)
		else $error("load beat produced a result");

	// The two red corners only coincide at the top edge, where the fraction is zero.
	a_edge_frac: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s3 && kind_s3 == KIND_SAMPLE && rsame_s3) |-> (fr_s3 == '0))
		else $error("red corners coincide with nonzero fraction");
`endif

endmodule

`default_nettype wire
